// ----- design/gpr_pkg.sv -----
// Shared types, register codes and color packing for the glyph pixel rasterizer.
package gpr_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [3:0] SCALE_MIN = 4'd1;
    localparam logic [3:0] SCALE_MAX = 4'd8;

    typedef struct packed {
        logic       glyph_bit;
        logic [3:0] glyph_column;
        logic [2:0] glyph_row;
        logic [9:0] origin_x;
        logic [9:0] origin_y;
    } glyph_req_t;

    typedef struct packed {
        logic [15:0] byte_address;
        logic [15:0] pixel_color;
        logic        last_pixel;
    } pixel_out_t;

    typedef struct packed {
        logic       buffer_select;
        logic [3:0] scale;
        logic [1:0] rotation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_BUFFER_SELECT = 3'd0,
        REG_SCALE         = 3'd1,
        REG_ROTATION      = 3'd2,
        REG_RED           = 3'd3,
        REG_GREEN         = 3'd4,
        REG_BLUE          = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rotation_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROWBASE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    function automatic logic [15:0] pack565(input cfg_t c);
        pack565 = {c.red[7:3], c.green[7:2], c.blue[7:3]};
    endfunction

endpackage

// ----- design/gpr_cfg.sv -----
// APB configuration register file for the glyph pixel rasterizer.
module gpr_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gpr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [gpr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [gpr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output gpr_pkg::cfg_t                     cfg
);

    gpr_pkg::cfg_t      cfg_reg;
    gpr_pkg::cfg_t      cfg_next;
    gpr_pkg::reg_index_t reg_idx;
    logic               wr_en;

    assign reg_idx = gpr_pkg::reg_index_t'(paddr[gpr_pkg::CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                gpr_pkg::REG_BUFFER_SELECT: cfg_next.buffer_select = pwdata[0];
                gpr_pkg::REG_SCALE:         cfg_next.scale         = pwdata[3:0];
                gpr_pkg::REG_ROTATION:      cfg_next.rotation      = pwdata[1:0];
                gpr_pkg::REG_RED:           cfg_next.red           = pwdata[7:0];
                gpr_pkg::REG_GREEN:         cfg_next.green         = pwdata[7:0];
                gpr_pkg::REG_BLUE:          cfg_next.blue          = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            gpr_pkg::REG_BUFFER_SELECT: prdata = gpr_pkg::CFG_DATA_W'(cfg_reg.buffer_select);
            gpr_pkg::REG_SCALE:         prdata = gpr_pkg::CFG_DATA_W'(cfg_reg.scale);
            gpr_pkg::REG_ROTATION:      prdata = gpr_pkg::CFG_DATA_W'(cfg_reg.rotation);
            gpr_pkg::REG_RED:           prdata = gpr_pkg::CFG_DATA_W'(cfg_reg.red);
            gpr_pkg::REG_GREEN:         prdata = gpr_pkg::CFG_DATA_W'(cfg_reg.green);
            gpr_pkg::REG_BLUE:          prdata = gpr_pkg::CFG_DATA_W'(cfg_reg.blue);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= gpr_pkg::cfg_t'{buffer_select: 1'b0,
                                       scale:         gpr_pkg::SCALE_MIN,
                                       rotation:      2'd0,
                                       red:           8'd0,
                                       green:         8'd0,
                                       blue:          8'd0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/glyph_pixel_rasterizer.sv -----
// Top level of the glyph pixel rasterizer: block scan sequencer and result registers.
//
// Usage:
//   s_ channel: one glyph request per handshake (bit, column, row, cell origin).
//   m_ channel: one pixel write per handshake: byte framebuffer address,
//     RGB565 color, and last_pixel on the final write caused by that request.
//   APB port: buffer_select, scale, rotation, red, green, blue at byte
//     addresses 0, 4, 8, 12, 16, 20. Write only while the block is idle.
// Sequence:
//   A clear bit is taken while idle and gives nothing. A set bit holds
//   s_ready low through a setup state for the rotated block origin, a row
//   base state for the multiply (buffer width times y), a scan state that
//   visits each block pixel in turn on a shared add/compare step, and a
//   flush state. One candidate pixel is held back until the next surviving
//   one (or the end of the block) is known, which decides last_pixel.
//   Dropped pixels (negative or past the buffer end) still take a scan step.
// Reset: synchronous, active low; the sequencer goes idle, outputs go invalid,
//   scale returns to 1 and all other config registers to 0.
// Stall: when m_ready is low the output register holds; the scan pauses while
//   both the output register and the held-back pixel are full.
module glyph_pixel_rasterizer #(
    parameter int GLYPH_WIDTH    = 8,
    parameter int GLYPH_HEIGHT   = 8,
    parameter int STATUS_WIDTH   = 40,
    parameter int STATUS_HEIGHT  = 320,
    parameter int ELEMENT_WIDTH  = 200,
    parameter int ELEMENT_HEIGHT = 40
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gpr_pkg::glyph_req_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gpr_pkg::pixel_out_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gpr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [gpr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [gpr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    // Coordinate range: origin up to 1023 plus up to 8x (larger glyph side + 16) pixels,
    // and negative reach of the same order; one extra bit for sign.
    localparam int DIM_MAX   = (GLYPH_WIDTH > GLYPH_HEIGHT) ? GLYPH_WIDTH : GLYPH_HEIGHT;
    localparam int COORD_MAX = 1023 + (DIM_MAX + 16) * 8;
    localparam int COORD_W   = $clog2(COORD_MAX + 1) + 1;
    localparam int BW_MAX    = (STATUS_WIDTH > ELEMENT_WIDTH) ? STATUS_WIDTH : ELEMENT_WIDTH;
    localparam int BW_W      = $clog2(BW_MAX + 1);
    localparam int LIN_MAX   = BW_MAX * COORD_MAX + COORD_MAX;
    localparam int LIN_W     = $clog2(LIN_MAX + 1) + 1;
    localparam int K_W       = $clog2(DIM_MAX + 16) + 2;

    gpr_pkg::cfg_t      cfg;
    gpr_pkg::state_t    state_reg, state_next;

    gpr_pkg::glyph_req_t item_reg;
    logic signed [COORD_W-1:0] px0_reg, py0_reg;
    logic signed [COORD_W-1:0] cur_px_reg, cur_py_reg;
    logic [LIN_W-1:0]   row0_reg, cur_row_reg;
    logic [2:0]         block_col_count_reg, block_row_count_reg;
    logic               pend_valid_reg;
    logic [15:0]        pend_addr_reg;
    logic               m_valid_reg;
    gpr_pkg::pixel_out_t m_data_reg;

    // config-derived
    logic [3:0]         s_eff;
    logic [2:0]         s_last;
    logic               dir_neg;
    logic [BW_W-1:0]    bw;
    logic [LIN_W-1:0]   bw_ext, lim;

    // setup datapath
    logic signed [K_W-1:0] a_k, n_k, w_k, h_k, kx, ky;
    logic                  off_one;
    logic signed [COORD_W-1:0] kx_ext, ky_ext, s_ext, x_ext, y_ext;
    logic signed [COORD_W-1:0] px0_next, py0_next;

    // scan datapath
    logic [LIN_W-1:0]   lin;
    logic               pix_ok;
    logic               e_wrap, z_wrap;

    // control
    logic               out_busy;
    logic               step_en, pix_take, out_load, out_last, item_load;

    gpr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Scale clamped to 1..8
    always_comb begin
        if (cfg.scale < gpr_pkg::SCALE_MIN) begin
            s_eff = gpr_pkg::SCALE_MIN;
        end else if (cfg.scale > gpr_pkg::SCALE_MAX) begin
            s_eff = gpr_pkg::SCALE_MAX;
        end else begin
            s_eff = cfg.scale;
        end
    end
    assign s_last  = 3'(s_eff - 4'd1);
    assign dir_neg = (gpr_pkg::rotation_t'(cfg.rotation) == gpr_pkg::ROT_180) ||
                     (gpr_pkg::rotation_t'(cfg.rotation) == gpr_pkg::ROT_270);
    assign bw      = cfg.buffer_select ? BW_W'(ELEMENT_WIDTH) : BW_W'(STATUS_WIDTH);
    assign bw_ext  = LIN_W'(bw);
    assign lim     = cfg.buffer_select ? LIN_W'(ELEMENT_WIDTH * ELEMENT_HEIGHT)
                                       : LIN_W'(STATUS_WIDTH * STATUS_HEIGHT);

    // Block origin: p0 = origin + k*s - off, per rotation.
    //   0:   kx = a,       ky = n
    //   90:  kx = H-1-n,   ky = a
    //   180: kx = W-a,     ky = H-n,  minus one
    //   270: kx = n+1,     ky = W-a,  minus one
    assign a_k = K_W'(item_reg.glyph_column);
    assign n_k = K_W'(item_reg.glyph_row);
    assign w_k = K_W'(GLYPH_WIDTH);
    assign h_k = K_W'(GLYPH_HEIGHT);

    always_comb begin
        kx = a_k;
        ky = n_k;
        unique case (gpr_pkg::rotation_t'(cfg.rotation))
            gpr_pkg::ROT_0: begin
                kx = a_k;
                ky = n_k;
            end
            gpr_pkg::ROT_90: begin
                kx = h_k - n_k - K_W'(1);
                ky = a_k;
            end
            gpr_pkg::ROT_180: begin
                kx = w_k - a_k;
                ky = h_k - n_k;
            end
            gpr_pkg::ROT_270: begin
                kx = n_k + K_W'(1);
                ky = w_k - a_k;
            end
            default: ;
        endcase
    end
    assign off_one  = dir_neg;
    assign kx_ext   = COORD_W'(kx);
    assign ky_ext   = COORD_W'(ky);
    assign s_ext    = COORD_W'(s_eff);
    assign x_ext    = COORD_W'(item_reg.origin_x);
    assign y_ext    = COORD_W'(item_reg.origin_y);
    assign px0_next = x_ext + kx_ext * s_ext - COORD_W'(off_one);
    assign py0_next = y_ext + ky_ext * s_ext - COORD_W'(off_one);

    // Pixel test: linear index = bw*py + px, kept only when px, py >= 0 and inside.
    assign lin    = cur_row_reg + LIN_W'(cur_px_reg);
    assign pix_ok = !cur_px_reg[COORD_W-1] && !cur_py_reg[COORD_W-1] && (lin < lim);
    assign e_wrap = (block_row_count_reg == s_last);
    assign z_wrap = (block_col_count_reg == s_last);

    assign out_busy = m_valid_reg && !m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gpr_pkg::ST_IDLE: begin
                if (s_valid && s_data.glyph_bit) begin
                    state_next = gpr_pkg::ST_SETUP;
                end
            end
            gpr_pkg::ST_SETUP:   state_next = gpr_pkg::ST_ROWBASE;
            gpr_pkg::ST_ROWBASE: state_next = gpr_pkg::ST_SCAN;
            gpr_pkg::ST_SCAN: begin
                if (step_en && e_wrap && z_wrap) begin
                    state_next = gpr_pkg::ST_FLUSH;
                end
            end
            gpr_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || !out_busy) begin
                    state_next = gpr_pkg::ST_IDLE;
                end
            end
            default: state_next = gpr_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready   = 1'b0;
        item_load = 1'b0;
        step_en   = 1'b0;
        out_last  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            gpr_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                item_load = s_valid;
            end
            gpr_pkg::ST_SCAN: begin
                step_en  = !(pend_valid_reg && out_busy);
                out_load = step_en && pix_ok && pend_valid_reg;
            end
            gpr_pkg::ST_FLUSH: begin
                out_last = 1'b1;
                out_load = pend_valid_reg && !out_busy;
            end
            default: ;
        endcase
    end
    assign pix_take = step_en && pix_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= gpr_pkg::ST_IDLE;
            block_col_count_reg <= '0;
            block_row_count_reg <= '0;
            pend_valid_reg      <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (step_en) begin
                block_row_count_reg <= e_wrap ? 3'd0 : block_row_count_reg + 3'd1;
                if (e_wrap) begin
                    block_col_count_reg <= z_wrap ? 3'd0 : block_col_count_reg + 3'd1;
                end
            end

            if (pix_take) begin
                pend_valid_reg <= 1'b1;
            end else if (out_load) begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (item_load) begin
            item_reg <= s_data;
        end
        if (state_reg == gpr_pkg::ST_SETUP) begin
            px0_reg <= px0_next;
            py0_reg <= py0_next;
        end
        if (state_reg == gpr_pkg::ST_ROWBASE) begin
            row0_reg    <= bw_ext * LIN_W'(py0_reg);
            cur_row_reg <= bw_ext * LIN_W'(py0_reg);
            cur_px_reg  <= px0_reg;
            cur_py_reg  <= py0_reg;
        end else if (step_en) begin
            if (e_wrap) begin
                // next column of the block: back to the first row
                cur_py_reg  <= py0_reg;
                cur_row_reg <= row0_reg;
                cur_px_reg  <= dir_neg ? cur_px_reg - COORD_W'(1) : cur_px_reg + COORD_W'(1);
            end else begin
                cur_py_reg  <= dir_neg ? cur_py_reg - COORD_W'(1) : cur_py_reg + COORD_W'(1);
                cur_row_reg <= dir_neg ? cur_row_reg - bw_ext : cur_row_reg + bw_ext;
            end
        end
        if (pix_take) begin
            pend_addr_reg <= 16'({lin, 1'b0});
        end
        if (out_load) begin
            m_data_reg.byte_address <= pend_addr_reg;
            m_data_reg.pixel_color  <= gpr_pkg::pack565(cfg);
            m_data_reg.last_pixel   <= out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A new block never starts with a held-back pixel from the previous one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gpr_pkg::ST_SETUP) |-> !pend_valid_reg)
        else $error("held-back pixel left over at block start");

    // The output register is never loaded over an unaccepted write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_valid_reg && !m_ready))
        else $error("output register overwritten while stalled");

    // Scan counters stay inside the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gpr_pkg::ST_SCAN) |->
            (block_col_count_reg <= s_last) && (block_row_count_reg <= s_last))
        else $error("block scan counter out of range");

    // Counters are back at zero whenever the block is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gpr_pkg::ST_IDLE) |->
            (block_col_count_reg == 3'd0) && (block_row_count_reg == 3'd0))
        else $error("block scan counters not cleared");

    // A final write leaves nothing held back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last) |=> !pend_valid_reg && (state_reg == gpr_pkg::ST_IDLE))
        else $error("pixel held back after final write");

endmodule
